>>> hw/rtl/epws_pkg.sv
`timescale 1ns / 1ps

package epws_pkg;

    // Geometry of the memory and of one transfer
    localparam int ADDR_W     = 17;
    localparam int LEN_W      = 14;
    localparam int PAGE_SIZE  = 256;
    localparam int MAX_LENGTH = 8192;
    localparam int PAGE_W     = $clog2(PAGE_SIZE);
    localparam int ROOM_W     = PAGE_W + 1;
    localparam int BANK_BIT   = 16;

    localparam logic [7:0] DEV_RESET = 8'hA0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Request word
    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] start_address;
        logic [LEN_W-1:0]  byte_count;
    } t_req;

    // Chunk word
    typedef struct packed {
        logic [7:0]        device_byte;
        logic [7:0]        address_high;
        logic [7:0]        address_low;
        logic [ADDR_W-1:0] chunk_address;
        logic [LEN_W-1:0]  chunk_length;
        logic              is_read;
        logic              last_chunk;
    } t_chunk;

    // Result of one pass through the chunk unit
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  rem_next;
        logic [ADDR_W-1:0] cursor_next;
        logic              last;
    } t_step;

endpackage

>>> hw/rtl/epws_chunk_unit.sv
`timescale 1ns / 1ps

module epws_chunk_unit (
    input  logic [epws_pkg::ADDR_W-1:0] i_cursor,
    input  logic [epws_pkg::LEN_W-1:0]  i_rem,
    input  logic                        i_single,
    output epws_pkg::t_step             o_step
);
    import epws_pkg::*;

    logic [ROOM_W-1:0] room;
    logic [LEN_W-1:0]  room_ext;
    logic [LEN_W-1:0]  len;

    // Bytes left up to the next page boundary
    assign room     = ROOM_W'(PAGE_SIZE) - ROOM_W'(i_cursor[PAGE_W-1:0]);
    assign room_ext = LEN_W'(room);

    // One compare and subtract picks the chunk and moves the cursor
    assign len = (i_single || (i_rem < room_ext)) ? i_rem : room_ext;

    always_comb begin
        o_step.len         = len;
        o_step.rem_next    = i_rem - len;
        o_step.cursor_next = i_cursor + ADDR_W'(len);
        o_step.last        = i_single || (i_rem == len);
    end

endmodule

>>> hw/rtl/eeprom_page_write_splitter.sv
`timescale 1ns / 1ps

// Splits one EEPROM transfer request into bus chunks. A write request is cut
// at page boundaries (partial head page, whole pages, tail); a read or a
// zero-length request gives a single chunk. After a request word is taken,
// the block emits one chunk per cycle while the output is not stalled, from
// a single shared chunk unit (page room, min, subtract, address add). A
// request gives at most 33 chunks with a 256-byte page and an 8192-byte cap.
// o_ready is high only between requests. Counts above the cap are clamped
// and addresses wrap at 17 bits. The device byte register (reset 0xA0) is
// written through the cfg channel and should only change between requests.
module eeprom_page_write_splitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  epws_pkg::t_req   i_req,
    output logic             o_valid,
    input  logic             i_ready,
    output epws_pkg::t_chunk o_chunk
);
    import epws_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [7:0]        r_dev;
    logic [ADDR_W-1:0] r_cursor, n_cursor;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic              r_read, n_read;
    logic              r_single, n_single;
    logic              r_out_valid, n_out_valid;
    t_chunk            r_out, n_out;

    t_step             step;
    logic [LEN_W-1:0]  count;
    logic              out_free;
    logic              take_req;

    epws_chunk_unit u_chunk (
        .i_cursor (r_cursor),
        .i_rem    (r_rem),
        .i_single (r_single),
        .o_step   (step)
    );

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign take_req    = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_chunk     = r_out;

    // Clamp the count
    assign count = (i_req.byte_count > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH)
                                                          : i_req.byte_count;

    // Sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_rem       = r_rem;
        n_read      = r_read;
        n_single    = r_single;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (take_req) begin
                    n_cursor = i_req.start_address;
                    n_rem    = count;
                    n_read   = (i_req.operation == OP_READ);
                    n_single = (i_req.operation == OP_READ) || (count == '0);
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    n_out.device_byte   = {r_dev[7:2], r_cursor[BANK_BIT], r_dev[0]};
                    n_out.address_high  = r_cursor[15:8];
                    n_out.address_low   = r_cursor[7:0];
                    n_out.chunk_address = r_cursor;
                    n_out.chunk_length  = step.len;
                    n_out.is_read       = r_read;
                    n_out.last_chunk    = step.last;
                    n_out_valid         = 1'b1;
                    n_cursor            = step.cursor_next;
                    n_rem               = step.rem_next;
                    if (step.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dev       <= DEV_RESET;
            r_cursor    <= '0;
            r_rem       <= '0;
            r_read      <= 1'b0;
            r_single    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cursor    <= n_cursor;
            r_rem       <= n_rem;
            r_read      <= n_read;
            r_single    <= n_single;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dev <= i_cfg_data;
            end
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_req_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_req |=> (r_state == S_RUN))
        else $error("request taken but sequencer not running");

    a_split_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !r_single) |-> (r_rem != '0))
        else $error("paged split running with nothing left");

    a_write_len_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.is_read) |-> (r_out.chunk_length <= LEN_W'(PAGE_SIZE)))
        else $error("write chunk longer than a page");

    a_write_ends_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.is_read && !r_out.last_chunk) |->
        ((LEN_W'(r_out.chunk_address[PAGE_W-1:0]) + r_out.chunk_length)
            == LEN_W'(PAGE_SIZE)))
        else $error("non-final write chunk does not end on a page boundary");
`endif

endmodule

>>> tb/sv/epws_chunk_checker.sv
`timescale 1ns / 1ps

module epws_chunk_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  epws_pkg::t_req   i_req,
    input  logic             i_chunk_valid,
    input  logic             i_chunk_ready,
    input  epws_pkg::t_chunk i_chunk,
    output int               o_fail_count,
    output int               o_pending
);
    import epws_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [7:0] device_reg = DEV_RESET;
    t_chunk     expected_chunks[$];
    int         fail_count = 0;

    // Count a failure; only the first few get printed
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] chunk check: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            note_failure($sformatf("%s expected 0x%0h, got 0x%0h", field, want, got));
        end
    endfunction

    // Build one chunk word; the bank bit replaces bit 1 of the device byte
    function automatic t_chunk make_chunk(input logic [ADDR_W-1:0] addr,
                                          input logic [LEN_W-1:0] len,
                                          input logic rd, input logic last);
        t_chunk c;
        c.device_byte   = {device_reg[7:2], addr[BANK_BIT], device_reg[0]};
        c.address_high  = addr[15:8];
        c.address_low   = addr[7:0];
        c.chunk_address = addr;
        c.chunk_length  = len;
        c.is_read       = rd;
        c.last_chunk    = last;
        return c;
    endfunction

    // Cut a request into page-bounded chunks (reads and empty requests: one chunk)
    function automatic void split_request(input t_req r);
        logic [ADDR_W-1:0] cursor;
        int remaining;
        int room;
        int len;
        cursor    = r.start_address;
        remaining = (r.byte_count > MAX_LENGTH) ? MAX_LENGTH : int'(r.byte_count);
        if (remaining == 0 || r.operation == OP_READ) begin
            expected_chunks.push_back(make_chunk(cursor, LEN_W'(remaining), r.operation, 1'b1));
        end else begin
            while (remaining > 0) begin
                room = PAGE_SIZE - (int'(cursor) % PAGE_SIZE);
                len  = (remaining < room) ? remaining : room;
                remaining -= len;
                expected_chunks.push_back(make_chunk(cursor, LEN_W'(len), OP_WRITE,
                                                     remaining == 0));
                cursor = cursor + ADDR_W'(len);
            end
        end
    endfunction

    // Match an outgoing word against the oldest expected chunk
    function automatic void compare_chunk(input t_chunk got);
        t_chunk want;
        if (expected_chunks.size() == 0) begin
            note_failure($sformatf("unexpected chunk word 0x%0h", got));
            return;
        end
        want = expected_chunks.pop_front();
        check_field("device_byte", want.device_byte, got.device_byte);
        check_field("address_high", want.address_high, got.address_high);
        check_field("address_low", want.address_low, got.address_low);
        check_field("chunk_address", want.chunk_address, got.chunk_address);
        check_field("chunk_length", want.chunk_length, got.chunk_length);
        check_field("is_read", want.is_read, got.is_read);
        check_field("last_chunk", want.last_chunk, got.last_chunk);
    endfunction

    // Watch all three channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            device_reg = DEV_RESET;
            expected_chunks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                device_reg = i_cfg_data;
            end
            if (i_chunk_valid && i_chunk_ready) begin
                compare_chunk(i_chunk);
            end
            if (i_req_valid && i_req_ready) begin
                split_request(i_req);
            end
        end
        o_pending    = expected_chunks.size();
        o_fail_count = fail_count;
    end

endmodule

>>> tb/sv/eeprom_page_write_splitter_test.sv
`timescale 1ns / 1ps

module eeprom_page_write_splitter_test;
    import epws_pkg::*;

    localparam int HALF_PERIOD      = 2;
    localparam int RESET_CYCLES     = 4;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_OFF_AT      = 300;     // chunk number where the sink stalls
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int CYCLE_LIMIT      = 600000;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    logic   [7:0] cfg_data = 8'h00;
    logic   req_valid = 1'b0;
    logic   req_ready;
    t_req   req       = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    t_chunk out_chunk;
    int     fail_count;
    int     pending;
    int     cycle_count = 0;
    bit     send_steady = 1'b0;

    eeprom_page_write_splitter i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_valid     (req_valid),
        .o_ready     (req_ready),
        .i_req       (req),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_chunk     (out_chunk)
    );

    epws_chunk_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req),
        .i_chunk_valid (out_valid),
        .i_chunk_ready (out_ready),
        .i_chunk       (out_chunk),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic t_req make_req(input logic op, input logic [ADDR_W-1:0] addr,
                                      input logic [LEN_W-1:0] count);
        t_req r;
        r.operation     = op;
        r.start_address = addr;
        r.byte_count    = count;
        return r;
    endfunction

    // Mostly small counts, some near page ends or the top of memory, a few oversized
    function automatic t_req random_request();
        logic op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0] count;
        int sel;
        op  = ($urandom_range(0, 9) < 3) ? OP_READ : OP_WRITE;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            addr = {9'($urandom_range(0, 511)), 8'($urandom_range(8'hE0, 8'hFF))};
        end else if (sel < 3) begin
            addr = 17'h1FE00 + ADDR_W'($urandom_range(0, 511));
        end else begin
            addr = ADDR_W'($urandom_range(0, 17'h1FFFF));
        end
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            count = LEN_W'($urandom_range(0, 300));
        end else if (sel < 8) begin
            count = LEN_W'($urandom_range(0, 1024));
        end else if (sel < 9) begin
            count = LEN_W'($urandom_range(0, MAX_LENGTH));
        end else begin
            count = LEN_W'($urandom_range(0, 16383));
        end
        return make_req(op, addr, count);
    endfunction

    // Offer one request word after a random gap (none while send_steady is set), return at its acceptance edge
    task automatic send_request(input t_req r);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
    endtask

    // Stop offering, wait for every expected chunk, then let the block go idle
    task automatic settle();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_device(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Chunk sink: random stalls per word, steady stretches, one long hold-off
    initial begin : chunk_sink
        int gap;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        while (!rst_n) @(posedge clk);
        out_ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (out_ready && out_valid) begin
                taken++;
                if (taken % 64 == 0) begin
                    steady = ($urandom_range(0, 3) == 0);
                end
                if (taken == HOLD_OFF_AT) begin
                    gap = HOLD_OFF_CYCLES;
                end else begin
                    gap = steady ? 0 : $urandom_range(0, 8);
                end
                if (gap != 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Request source
    initial begin : stimulus
        logic [7:0] dev_value;
        while (!rst_n) @(posedge clk);

        // Directed: empty requests, page edges, clamping, wrap and bank crossing
        send_request(make_req(OP_WRITE, 17'h00000, 14'd0));
        send_request(make_req(OP_READ,  17'h1FFFF, 14'd0));
        send_request(make_req(OP_WRITE, 17'h00000, 14'd1));
        send_request(make_req(OP_WRITE, 17'h00000, 14'd256));
        send_request(make_req(OP_WRITE, 17'h00080, 14'd256));
        send_request(make_req(OP_WRITE, 17'h000FF, 14'd2));
        send_request(make_req(OP_WRITE, 17'h00001, 14'd8192));
        send_request(make_req(OP_WRITE, 17'h00000, 14'd8193));
        send_request(make_req(OP_WRITE, 17'h12345, 14'h3FFF));
        send_request(make_req(OP_READ,  17'h00000, 14'h3FFF));
        send_request(make_req(OP_READ,  17'h1FFFF, 14'd5));
        send_request(make_req(OP_WRITE, 17'h1FFFF, 14'd2));
        send_request(make_req(OP_WRITE, 17'h1FF00, 14'd8192));
        send_request(make_req(OP_WRITE, 17'h0FFF0, 14'd40));
        send_request(make_req(OP_WRITE, 17'h10000, 14'd1));
        send_request(make_req(OP_READ,  17'h10000, 14'd8192));
        send_request(make_req(OP_WRITE, 17'h0FF00, 14'd255));
        send_request(make_req(OP_READ,  17'h0ABCD, 14'd1));
        send_request(make_req(OP_WRITE, 17'h1FF80, 14'd300));
        settle();

        // Random phases, each under its own device byte
        for (int p = 0; p < 4; p++) begin
            if (p == 0) begin
                dev_value = 8'h00;
            end else if (p == 1) begin
                dev_value = 8'hFF;
            end else begin
                dev_value = 8'($urandom_range(0, 255));
            end
            write_device(dev_value);
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (k % 32 == 0) begin
                    send_steady = ($urandom_range(0, 3) == 0);
                end
                send_request(random_request());
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
